### rtl/core/oli_pkg.sv
package oli_pkg;

    // default list capacity
    localparam int LIST_DEPTH = 16;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 5;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;

    // most results one read-out gives
    localparam int RESULT_CAP = 16;

    // op codes
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic [INDEX_W-1:0]       index;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] item;
        logic [POS_W-1:0]         position;
        logic                     last;
    } t_out_word;

    // shift commands broadcast along the cell chain
    typedef struct packed {
        logic push;   // every cell takes its front neighbor
        logic del;    // cells at or behind the delete point take their back neighbor
        logic rot;    // front part of the chain rotates by one toward the front
    } t_cell_ctl;

endpackage

### rtl/core/oli_cell.sv
module oli_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                        i_clk,
    input  oli_pkg::t_cell_ctl          i_ctl,
    input  logic [IDX_W-1:0]            i_del_pos,
    input  logic [IDX_W-1:0]            i_tail,
    input  logic [oli_pkg::DATA_W-1:0]  i_prev,
    input  logic [oli_pkg::DATA_W-1:0]  i_next,
    input  logic [oli_pkg::DATA_W-1:0]  i_wrap,
    output logic [oli_pkg::DATA_W-1:0]  o_data
);
    import oli_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.push) begin
            n_data = i_prev;
        end else if (i_ctl.del && (MY_IDX >= i_del_pos)) begin
            n_data = i_next;
        end else if (i_ctl.rot) begin
            if (MY_IDX == i_tail) begin
                n_data = i_wrap;
            end else if (MY_IDX < i_tail) begin
                n_data = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### rtl/core/ordered_list_insert_delete.sv
// Bounded ordered list of signed 32-bit values held in a chain of DEPTH cells,
// cell 0 being the front. A push (op 0) shifts the whole chain back by one and
// puts the value in cell 0; on a full list the value is dropped with status
// full. A delete (op 1) closes the gap by pulling every cell at or behind the
// index forward; an empty list gives status empty, an index at or past the
// count gives status invalid. A read-out (op 2) rotates the occupied cells
// toward the front one place a cycle, pausing while a result cannot be taken,
// and emits cell 0 each time, so the list leaves front to back and is back in
// its original order once all count entries have gone round; an empty list
// gives one result with status empty. Any other op code gives one ok result.
// Every op except a non-empty read-out gives exactly one result word with last
// set. A new word is accepted every cycle as long as the result word register
// is drained and no read-out is running. A read-out holds off the input until
// the rotation of the cell chain has gone through all count entries (count
// being the list length); with DEPTH above sixteen only the first sixteen
// entries are emitted, the rest of the rotation runs silently. The cells need
// no clearing after reset: only entries below count are ever read.
module ordered_list_insert_delete #(
    parameter int DEPTH = oli_pkg::LIST_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  oli_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output oli_pkg::t_out_word o_out_word
);
    import oli_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    // common width for comparing count, step and the input index
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    // controller states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [IDX_W-1:0] r_step;
    logic [IDX_W-1:0] n_step;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_word        r_out_word;
    t_out_word        n_out_word;

    logic [DATA_W-1:0] w_cell_q [DEPTH];
    t_cell_ctl         w_ctl;

    // decode of the incoming word
    logic             w_accept;
    logic             w_out_free;
    logic             w_full;
    logic             w_empty;
    logic             w_idx_bad;
    logic [CMP_W-1:0] w_idx_ext;
    logic [CMP_W-1:0] w_cnt_ext;
    logic [IDX_W-1:0] w_del_pos;
    logic [IDX_W-1:0] w_tail;

    // read-out step
    logic [CMP_W-1:0] w_step_ext;
    logic             w_emit;
    logic             w_rot_go;
    logic             w_step_end;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_idx_ext = CMP_W'(i_in_word.index);
    assign w_cnt_ext = CMP_W'(r_count);
    assign w_idx_bad = (w_idx_ext >= w_cnt_ext);
    // only used when the index is below count, so it fits a cell index
    assign w_del_pos = w_idx_ext[IDX_W-1:0];
    // last occupied cell, meaningful while the list is not empty
    assign w_tail    = w_cnt_ext[IDX_W-1:0] - IDX_W'(1);

    // read-out: emit while under the result cap, then rotate silently
    assign w_step_ext = CMP_W'(r_step);
    assign w_emit     = (w_step_ext < CMP_W'(RESULT_CAP));
    assign w_rot_go   = (r_state == ST_READ) && (!w_emit || w_out_free);
    assign w_step_end = (r_step == w_tail);

    always_comb begin
        w_ctl.push = w_accept && (i_in_word.op == OP_PUSH) && !w_full;
        w_ctl.del  = w_accept && (i_in_word.op == OP_DEL) && !w_empty && !w_idx_bad;
        w_ctl.rot  = w_rot_go;
    end

    // cell chain: push comes in at the front, delete and rotate pull from behind
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_prev;
        logic [DATA_W-1:0] w_next;

        if (g == 0) begin : g_front
            assign w_prev = i_in_word.value;
        end else begin : g_mid_prev
            assign w_prev = w_cell_q[g-1];
        end

        if (g == DEPTH - 1) begin : g_back
            assign w_next = w_cell_q[g];
        end else begin : g_mid_next
            assign w_next = w_cell_q[g+1];
        end

        oli_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_del_pos (w_del_pos),
            .i_tail    (w_tail),
            .i_prev    (w_prev),
            .i_next    (w_next),
            .i_wrap    (w_cell_q[0]),
            .o_data    (w_cell_q[g])
        );
    end

    // controller, count and result word register
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;

        if (w_accept) begin
            // single-result default
            n_out_word.status   = STAT_OK;
            n_out_word.item     = '0;
            n_out_word.position = '0;
            n_out_word.last     = 1'b1;
            n_out_valid         = 1'b1;
            case (i_in_word.op)
                OP_PUSH: begin
                    if (w_full) begin
                        n_out_word.status = STAT_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_DEL: begin
                    if (w_empty) begin
                        n_out_word.status = STAT_EMPTY;
                    end else if (w_idx_bad) begin
                        n_out_word.status = STAT_INVALID;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                OP_READ: begin
                    if (w_empty) begin
                        n_out_word.status = STAT_EMPTY;
                    end else begin
                        // results come from the rotation, not from here
                        n_out_valid = r_out_valid && !i_out_ready;
                        n_out_word  = r_out_word;
                        n_state     = ST_READ;
                        n_step      = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (w_rot_go) begin
            if (w_emit) begin
                n_out_valid         = 1'b1;
                n_out_word.status   = STAT_OK;
                n_out_word.item     = $signed(w_cell_q[0]);
                n_out_word.position = w_step_ext[POS_W-1:0];
                n_out_word.last     = w_step_end ||
                                      (w_step_ext == CMP_W'(RESULT_CAP - 1));
            end
            if (w_step_end) begin
                n_state = ST_IDLE;
            end else begin
                n_step = r_step + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import oli_pkg::*;

    localparam int DEPTH       = LIST_DEPTH;
    localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int RAND_WORDS  = 480;

    // op code the block treats as a plain no-op
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // predicted list contents and the result words they lead to
    class list_scoreboard;
        logic signed [DATA_W-1:0] cells [DEPTH];
        int unsigned              fill;
        t_out_word                due_q [$];
        int                       errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void queue_result(logic [STATUS_W-1:0] st, logic signed [DATA_W-1:0] val,
                                   logic [POS_W-1:0] pos, logic fin);
            t_out_word r;
            r.status   = st;
            r.item     = val;
            r.position = pos;
            r.last     = fin;
            due_q.push_back(r);
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction

        // apply one accepted input word to the list and queue its results
        function void note_word(t_in_word w);
            int unsigned n;
            case (w.op)
                OP_PUSH: begin
                    if (fill >= DEPTH) begin
                        queue_result(STAT_FULL, '0, '0, 1'b1);
                    end else begin
                        for (int i = fill; i > 0; i--) cells[i] = cells[i-1];
                        cells[0] = w.value;
                        fill++;
                        queue_result(STAT_OK, '0, '0, 1'b1);
                    end
                end
                OP_DEL: begin
                    if (fill == 0) begin
                        queue_result(STAT_EMPTY, '0, '0, 1'b1);
                    end else if (w.index >= fill) begin
                        queue_result(STAT_INVALID, '0, '0, 1'b1);
                    end else begin
                        for (int i = w.index; i + 1 < fill; i++) cells[i] = cells[i+1];
                        fill--;
                        queue_result(STAT_OK, '0, '0, 1'b1);
                    end
                end
                OP_READ: begin
                    if (fill == 0) begin
                        queue_result(STAT_EMPTY, '0, '0, 1'b1);
                    end else begin
                        n = (fill > RESULT_CAP) ? RESULT_CAP : fill;
                        for (int i = 0; i < n; i++)
                            queue_result(STAT_OK, cells[i], POS_W'(i), i == n - 1);
                    end
                end
                default: begin
                    queue_result(STAT_OK, '0, '0, 1'b1);
                end
            endcase
        endfunction

        // compare one accepted result word with the oldest one due
        task check_word(t_out_word got);
            t_out_word want;
            if (due_q.size() == 0) begin
                report($sformatf("result word with nothing outstanding: status %0d item %0d",
                                 got.status, got.item));
            end else begin
                want = due_q.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status got %0d want %0d", got.status, want.status));
                if (got.item !== want.item)
                    report($sformatf("item got %0d want %0d", got.item, want.item));
                if (got.position !== want.position)
                    report($sformatf("position got %0d want %0d",
                                     got.position, want.position));
                if (got.last !== want.last)
                    report($sformatf("last got %0d want %0d", got.last, want.last));
            end
        endtask
    endclass

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;

    logic      calm = 1'b0;  // no idling on either side while set
    int        stall_cycles = 0;

    list_scoreboard sb = new();

    ordered_list_insert_delete #(
        .DEPTH       (DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver side: stalls at random, about 16 percent of the time, unless calm
    always @(posedge i_clk) begin
        if (calm)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 16);
    end

    // result words are checked at the edge that accepts them
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            sb.check_word(out_word);
    end

    // watchdog on cycles where no word moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_in_word make_word(logic [OP_W-1:0] op,
                                           logic signed [DATA_W-1:0] val,
                                           logic [INDEX_W-1:0] idx);
        t_in_word w;
        w.op    = op;
        w.value = val;
        w.index = idx;
        return w;
    endfunction

    // random word, biased toward growing or shrinking the list
    function automatic t_in_word pick_word(bit filling, int unsigned len);
        t_in_word    w;
        int unsigned r;
        w.value = $urandom;
        w.index = INDEX_W'($urandom_range(31));
        r = $urandom_range(99);
        if (r < 5)
            w.op = OP_SPARE;
        else if (r < 17)
            w.op = OP_READ;
        else if (r < (filling ? 75 : 35))
            w.op = OP_PUSH;
        else
            w.op = OP_DEL;
        // mostly delete inside the list, now and then past its end
        if (w.op == OP_DEL && len != 0 && $urandom_range(9) < 8)
            w.index = INDEX_W'($urandom_range(len - 1));
        // extremes of the value now and then
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0: w.value = 32'sh8000_0000;
                1: w.value = 32'sh7fff_ffff;
                2: w.value = '0;
                default: w.value = -32'sd1;
            endcase
        end
        return w;
    endfunction

    // drive one word; it is noted in the scoreboard at its accepting edge
    task automatic send_word(t_in_word w);
        while (!calm && $urandom_range(99) < 16) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sb.note_word(w);
    endtask

    initial begin
        bit filling;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list cases and the spare op code
        send_word(make_word(OP_READ, '0, '0));
        send_word(make_word(OP_DEL, '0, '0));
        send_word(make_word(OP_SPARE, -32'sd1, 5'd31));
        // value extremes
        send_word(make_word(OP_PUSH, 32'sh8000_0000, '0));
        send_word(make_word(OP_PUSH, 32'sh7fff_ffff, '0));
        send_word(make_word(OP_PUSH, '0, '0));
        send_word(make_word(OP_PUSH, -32'sd1, '0));
        send_word(make_word(OP_READ, '0, '0));
        // index past the end, at the count, at the back and at the front
        send_word(make_word(OP_DEL, '0, 5'd31));
        send_word(make_word(OP_DEL, '0, 5'd4));
        send_word(make_word(OP_DEL, '0, 5'd3));
        send_word(make_word(OP_DEL, '0, 5'd0));
        // fill up, push on a full list, full read-out
        for (int i = 0; i < DEPTH - 2; i++)
            send_word(make_word(OP_PUSH, $urandom, '0));
        send_word(make_word(OP_PUSH, 32'sh1234_5678, '0));
        send_word(make_word(OP_READ, '0, '0));
        send_word(make_word(OP_DEL, '0, 5'(DEPTH - 1)));
        send_word(make_word(OP_DEL, '0, 5'd7));

        filling = 1'b1;
        for (int n = 0; n < RAND_WORDS; n++) begin
            // hold off until every result word has drained
            if (n == RAND_WORDS / 2) begin
                in_valid <= 1'b0;
                do @(posedge i_clk); while (sb.pending() != 0);
            end
            if (n == 300) calm <= 1'b1;
            if (n == 380) calm <= 1'b0;
            if (sb.fill == 0)
                filling = 1'b1;
            else if (sb.fill >= DEPTH && $urandom_range(2) == 0)
                filling = 1'b0;
            send_word(pick_word(filling, sb.fill));
        end
        in_valid <= 1'b0;

        // drain, then give the block time for any stray word
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
rtl/core/oli_pkg.sv
rtl/core/oli_cell.sv
rtl/core/ordered_list_insert_delete.sv
tb/tb_top.sv
